// ===== rtl/xor_sprite_draw_engine_assert.svh =====
// Assertion macros for the sprite draw engine
`ifndef XOR_SPRITE_DRAW_ENGINE_ASSERT_SVH
`define XOR_SPRITE_DRAW_ENGINE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define XSDE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define XSDE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/xsde_pkg.sv =====
// Shared types, codes and helpers of the sprite draw engine
package xsde_pkg;

   localparam int SPRITE_BITS = 8;
   localparam int SPRITE_MSB  = 7;
   localparam int COL_W       = 8;

   typedef enum logic [1:0] {
      OP_DRAW  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [3:0] row_index;
      logic [7:0] sprite_byte;
      logic       last_row;
      logic [4:0] read_line;
   } req_type;

   typedef struct packed {
      logic        collision;
      logic [63:0] line_bits;
      logic        is_read;
   } rsp_type;

   // What one pixel lane reports to the merge stage
   typedef struct packed {
      logic             hit;
      logic             flip;
      logic [COL_W-1:0] col;
   } lane_type;

   // Remainder of an 8-bit value by a modulus of at least 8 (restoring steps)
   function automatic logic [7:0] mod_small(input logic [7:0] value,
                                            input logic [7:0] modulus);
      logic [11:0] rem;
      logic [11:0] step;
      rem = {4'd0, value};
      for (int k = 4; k >= 0; k--) begin
         step = {4'd0, modulus} << k;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[7:0];
   endfunction

endpackage

// ===== rtl/xsde_lane.sv =====
// One pixel lane: clip, flip and collision test for a single sprite bit
module xsde_lane import xsde_pkg::*; #(
   parameter int SCREEN_WIDTH = 64
) (
   input  logic [SCREEN_WIDTH-1:0] line_q,
   input  logic [COL_W-1:0]        col,
   input  logic                    pix_bit,
   output lane_type                lane
);

   localparam int XW = $clog2(SCREEN_WIDTH);

   logic in_range;
   logic old_pix;

   // Clip at the right edge and pick the pixel under this lane
   always_comb begin
      in_range  = (col < COL_W'(SCREEN_WIDTH));
      old_pix   = in_range ? line_q[col[XW-1:0]] : 1'b0;
      lane.col  = col;
      lane.flip = pix_bit & in_range;
      lane.hit  = pix_bit & in_range & old_pix;
   end

endmodule

// ===== rtl/xsde_merge.sv =====
// Merge stage: fold lane flips into the new line and OR the collisions
module xsde_merge import xsde_pkg::*; #(
   parameter int SCREEN_WIDTH = 64
) (
   input  lane_type                lanes [SPRITE_BITS],
   input  logic [SCREEN_WIDTH-1:0] line_q,
   input  logic                    line_ok,
   output logic [SCREEN_WIDTH-1:0] line_d,
   output logic                    hit_any
);

   // Toggle every column that some lane lands on
   always_comb begin
      for (int c = 0; c < SCREEN_WIDTH; c++) begin
         line_d[c] = line_q[c];
         for (int i = 0; i < SPRITE_BITS; i++) begin
            if (lanes[i].flip && (lanes[i].col == COL_W'(c))) begin
               line_d[c] = ~line_q[c];
            end
         end
      end
   end

   // Collect collisions, only for lines on the screen
   always_comb begin
      hit_any = 1'b0;
      for (int i = 0; i < SPRITE_BITS; i++) begin
         hit_any = hit_any | lanes[i].hit;
      end
      hit_any = hit_any & line_ok;
   end

endmodule

// ===== rtl/xor_sprite_draw_engine.sv =====
// Sprite draw engine: XOR sprite rows into a one-bit frame store
// Each accepted request goes through line fetch, then merge and write back, before the next
// is taken, set by the read-modify-write of one line in the single-port frame memory.
// Its result is then loaded into the output register, or parked while the output is busy;
// a parked result holds off new requests. A loaded result waits there while the next is taken.
// Reset: clears control state, the collision flag and all line valid bits; screen reads blank.
module xor_sprite_draw_engine import xsde_pkg::*; #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   `include "xor_sprite_draw_engine_assert.svh"

   localparam int LINE_AW = $clog2(SCREEN_HEIGHT);
   localparam int VIS_W   = (SCREEN_WIDTH < 64) ? SCREEN_WIDTH : 64;

   state_type state_ff, state_in;
   req_type   req_ff;

   logic [SCREEN_WIDTH-1:0]  frame_mem [SCREEN_HEIGHT];
   logic [SCREEN_HEIGHT-1:0] row_valid_ff;
   logic [SCREEN_WIDTH-1:0]  rd_line_ff;
   logic                     rd_ok_ff;
   logic [LINE_AW-1:0]       addr_ff;
   logic                     on_screen_ff;
   logic [7:0]               xs_ff;
   logic                     accum_ff, accum_in;
   rsp_type                  pend_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff;

   logic [7:0]              xs;
   logic [7:0]              ys;
   logic [7:0]              rl;
   logic [8:0]              addr_full;
   logic                    on_screen;
   logic [SCREEN_WIDTH-1:0] line_q;
   logic [SCREEN_WIDTH-1:0] line_d;
   logic                    hit_any;
   lane_type                lanes [SPRITE_BITS];
   logic [63:0]             read_bits;
   logic                    is_draw, is_clear, is_read;
   logic                    res_needed;
   rsp_type                 res_data;
   logic                    out_free;
   logic                    load_out;
   logic                    accept;

   assign accept   = req_valid & req_ready;
   assign is_draw  = (req_ff.opcode == OP_DRAW);
   assign is_clear = (req_ff.opcode == OP_CLEAR);
   assign is_read  = (req_ff.opcode == OP_READ);
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Wrap coordinates and form the line address
   always_comb begin
      xs        = mod_small(req_ff.x_pos, 8'(SCREEN_WIDTH));
      ys        = mod_small(req_ff.y_pos, 8'(SCREEN_HEIGHT));
      rl        = mod_small({3'd0, req_ff.read_line}, 8'(SCREEN_HEIGHT));
      addr_full = is_read ? {1'b0, rl} : ({1'b0, ys} + {5'd0, req_ff.row_index});
      on_screen = (addr_full < 9'(SCREEN_HEIGHT));
   end

   // Fetch the line and write back the merged line
   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         rd_line_ff <= frame_mem[addr_full[LINE_AW-1:0]];
      end
      if ((state_ff == ST_EXEC) && is_draw && on_screen_ff) begin
         frame_mem[addr_ff] <= line_d;
      end
   end

   // Latch the address side of the fetch
   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         rd_ok_ff     <= row_valid_ff[addr_full[LINE_AW-1:0]];
         addr_ff      <= addr_full[LINE_AW-1:0];
         on_screen_ff <= on_screen;
         xs_ff        <= xs;
      end
   end

   // Track written lines; clear drops them all at once
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if ((state_ff == ST_EXEC) && is_clear) begin
         row_valid_ff <= '0;
      end else if ((state_ff == ST_EXEC) && is_draw && on_screen_ff) begin
         row_valid_ff[addr_ff] <= 1'b1;
      end
   end

   // A never written line reads blank
   assign line_q = rd_ok_ff ? rd_line_ff : '0;

   // Pixel lanes, one for each sprite bit
   for (genvar i = 0; i < SPRITE_BITS; i++) begin : g_lane
      xsde_lane #(
         .SCREEN_WIDTH (SCREEN_WIDTH)
      ) u_lane (
         .line_q  (line_q),
         .col     (xs_ff + COL_W'(i)),
         .pix_bit (req_ff.sprite_byte[SPRITE_MSB-i]),
         .lane    (lanes[i])
      );
   end

   xsde_merge #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_merge (
      .lanes   (lanes),
      .line_q  (line_q),
      .line_ok (on_screen_ff),
      .line_d  (line_d),
      .hit_any (hit_any)
   );

   // Restart the collision flag on row zero, then accumulate
   assign accum_in = ((req_ff.row_index == 4'd0) ? 1'b0 : accum_ff) | hit_any;

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= 1'b0;
      end else if ((state_ff == ST_EXEC) && is_draw) begin
         accum_ff <= accum_in;
      end
   end

   // Map columns to output bits, column zero at the top
   always_comb begin
      read_bits = '0;
      for (int c = 0; c < VIS_W; c++) begin
         read_bits[63-c] = line_q[c];
      end
   end

   // Build the result
   always_comb begin
      res_needed = (is_draw && req_ff.last_row) || is_read;
      res_data.collision = is_read ? 1'b0 : accum_in;
      res_data.line_bits = is_read ? read_bits : 64'd0;
      res_data.is_read   = is_read;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (res_needed && !out_free) ? ST_HOLD : ST_IDLE;
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs
   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_FETCH: load_out  = 1'b0;
         ST_EXEC:  load_out  = res_needed & out_free;
         ST_HOLD:  load_out  = out_free;
         default:  load_out  = 1'b0;
      endcase
      rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Park a result that found the output busy; load the output register
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         pend_ff <= res_data;
      end
      if (load_out) begin
         rsp_ff <= (state_ff == ST_HOLD) ? pend_ff : res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `XSDE_ASSERT_NEXT(a_accept_fetch, req_valid && req_ready, state_ff == ST_FETCH, "accepted request did not start a fetch")
   `XSDE_ASSERT_SAME(a_hold_busy, state_ff == ST_HOLD, rsp_valid_ff, "result parked with output free")
   `XSDE_ASSERT_SAME(a_read_no_coll, rsp_valid && rsp_data.is_read, !rsp_data.collision, "read result carries collision")

endmodule

// ===== tb/tb_xor_sprite_draw_engine.sv =====
// Self-checking testbench for the XOR sprite draw engine with a shadow frame buffer
module tb_xor_sprite_draw_engine import xsde_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W = 64;
   localparam int SCREEN_H = 32;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Shadow copy of the screen: bit 63 of each line is column 0
   logic [63:0] shadow_screen [SCREEN_H];
   logic        shadow_collision;
   rsp_type     pending_responses [$];
   int          mismatch_count;
   int          idle_pct;
   int          stall_pct;

   // Sprite being sent, kept so that it can be drawn again to force collisions
   logic [7:0]  sprite_rows [16];
   logic [7:0]  sprite_x;
   logic [7:0]  sprite_y;
   int          sprite_len;

   xor_sprite_draw_engine #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one accepted request to the shadow state and queue its response
   function automatic void apply_request(input req_type r);
      int      col_start;
      int      line_no;
      int      px;
      rsp_type rsp;
      rsp = '0;
      case (opcode_type'(r.opcode))
         OP_DRAW: begin
            col_start = int'(r.x_pos) % SCREEN_W;
            line_no   = (int'(r.y_pos) % SCREEN_H) + int'(r.row_index);
            if (r.row_index == 4'd0) begin
               shadow_collision = 1'b0;
            end
            // clip at the bottom and right edges, never wrap
            if (line_no < SCREEN_H) begin
               for (int c = 0; c < SPRITE_BITS; c++) begin
                  px = col_start + c;
                  if (px < SCREEN_W && r.sprite_byte[SPRITE_MSB - c]) begin
                     if (shadow_screen[line_no][63 - px]) begin
                        shadow_collision = 1'b1;
                     end
                     shadow_screen[line_no][63 - px] = ~shadow_screen[line_no][63 - px];
                  end
               end
            end
            if (r.last_row) begin
               rsp.collision = shadow_collision;
               pending_responses.push_back(rsp);
            end
         end
         OP_CLEAR: begin
            for (int l = 0; l < SCREEN_H; l++) begin
               shadow_screen[l] = '0;
            end
         end
         OP_READ: begin
            rsp.line_bits = shadow_screen[int'(r.read_line) % SCREEN_H];
            rsp.is_read   = 1'b1;
            pending_responses.push_back(rsp);
         end
         default: begin
         end
      endcase
   endfunction

   // Build requests; fields the opcode does not use carry random values
   function automatic req_type make_draw(input logic [7:0] x, input logic [7:0] y,
                                         input logic [3:0] row, input logic [7:0] bits,
                                         input logic last);
      req_type r;
      r.opcode      = OP_DRAW;
      r.x_pos       = x;
      r.y_pos       = y;
      r.row_index   = row;
      r.sprite_byte = bits;
      r.last_row    = last;
      r.read_line   = 5'($urandom_range(0, 31));
      return r;
   endfunction

   function automatic req_type make_other(input opcode_type op, input logic [4:0] line_sel);
      req_type r;
      r.x_pos       = 8'($urandom_range(0, 255));
      r.y_pos       = 8'($urandom_range(0, 255));
      r.row_index   = 4'($urandom_range(0, 15));
      r.sprite_byte = 8'($urandom_range(0, 255));
      r.last_row    = 1'($urandom_range(0, 1));
      r.opcode      = op;
      r.read_line   = line_sel;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      if (mismatch_count < 40) begin
         $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
      end
      mismatch_count++;
   endtask

   // Hold one request on the bus until it is taken, idling beforehand at random
   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      apply_request(r);
   endtask

   // Send the stored sprite as rows 0..len-1, last row marked
   task automatic send_sprite();
      for (int k = 0; k < sprite_len; k++) begin
         send_request(make_draw(sprite_x, sprite_y, 4'(k), sprite_rows[k],
                                k == sprite_len - 1));
      end
   endtask

   // Drive the response side ready at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Compare each accepted response with the oldest pending one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with none pending", '0, rsp_data.line_bits);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.collision !== want.collision) begin
               report_mismatch("collision", 64'(want.collision), 64'(rsp_data.collision));
            end
            if (rsp_data.line_bits !== want.line_bits) begin
               report_mismatch("line_bits", want.line_bits, rsp_data.line_bits);
            end
            if (rsp_data.is_read !== want.is_read) begin
               report_mismatch("is_read", 64'(want.is_read), 64'(rsp_data.is_read));
            end
         end
      end
   end

   // Pixels at the top-left corner, drawn and erased again
   task automatic test_corner_pixels();
      send_request(make_draw(8'd0, 8'd0, 4'd0, 8'hFF, 1'b1));
      send_request(make_other(OP_READ, 5'd0));
      send_request(make_draw(8'd0, 8'd0, 4'd0, 8'hFF, 1'b1));
      send_request(make_other(OP_READ, 5'd0));
   endtask

   // Clip past the right and bottom edges; wrap x and y into the screen first
   task automatic test_edge_clipping();
      send_request(make_draw(8'd60, 8'd31, 4'd0, 8'hFF, 1'b0));
      send_request(make_draw(8'd60, 8'd31, 4'd1, 8'hFF, 1'b1));
      send_request(make_draw(8'd255, 8'd255, 4'd15, 8'h80, 1'b1));
      send_request(make_draw(8'd255, 8'd255, 4'd0, 8'h81, 1'b1));
      send_request(make_other(OP_READ, 5'd31));
   endtask

   // Empty sprite, collision found on a middle row, and a row 0 that never comes
   task automatic test_collision_flag();
      send_request(make_draw(8'd8, 8'd4, 4'd0, 8'h00, 1'b1));
      send_request(make_draw(8'd8, 8'd4, 4'd0, 8'hFF, 1'b1));
      send_request(make_draw(8'd8, 8'd3, 4'd0, 8'h00, 1'b0));
      send_request(make_draw(8'd8, 8'd3, 4'd1, 8'h81, 1'b0));
      send_request(make_draw(8'd8, 8'd3, 4'd2, 8'h00, 1'b1));
      send_request(make_draw(8'd200, 8'd100, 4'd3, 8'h00, 1'b1));
   endtask

   // Clear blanks the screen but leaves the collision flag alone
   task automatic test_clear_screen();
      send_request(make_draw(8'd0, 8'd10, 4'd0, 8'hA5, 1'b0));
      send_request(make_draw(8'd0, 8'd10, 4'd0, 8'h24, 1'b0));
      send_request(make_other(OP_CLEAR, 5'd10));
      send_request(make_other(OP_READ, 5'd10));
      send_request(make_draw(8'd0, 8'd10, 4'd1, 8'h00, 1'b1));
      send_request(make_other(OP_READ, 5'd4));
   endtask

   // Unused opcode changes nothing and returns nothing
   task automatic test_unused_opcode();
      send_request(make_other(OP_NONE, 5'd0));
      send_request(make_other(OP_READ, 5'd0));
   endtask

   // Mostly well-formed sprites with random content, plus reads, clears and noise
   task automatic test_random_traffic(input int target);
      int sent;
      int pick;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            // redraw the previous sprite now and then so that pixels get erased
            if (sprite_len == 0 || $urandom_range(0, 3) != 0) begin
               sprite_x   = 8'($urandom_range(0, 255));
               sprite_y   = 8'($urandom_range(0, 255));
               sprite_len = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 6);
               for (int k = 0; k < 16; k++) begin
                  sprite_rows[k] = ($urandom_range(0, 9) == 0) ? 8'h00
                                                               : 8'($urandom_range(0, 255));
               end
            end
            send_sprite();
            sent += sprite_len;
         end else if (pick < 80) begin
            send_request(make_other(OP_READ, 5'($urandom_range(0, 31))));
            sent++;
         end else if (pick < 83) begin
            send_request(make_other(OP_CLEAR, 5'($urandom_range(0, 31))));
            sent++;
         end else if (pick < 94) begin
            send_request(make_draw(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1))));
            sent++;
         end else begin
            send_request(make_other(OP_NONE, 5'($urandom_range(0, 31))));
         end
      end
   endtask

   initial begin
      req_valid        <= 1'b0;
      req_data         <= '0;
      reset            <= 1'b1;
      idle_pct         = 0;
      stall_pct        = 0;
      mismatch_count   = 0;
      shadow_collision = 1'b0;
      sprite_len       = 0;
      for (int l = 0; l < SCREEN_H; l++) begin
         shadow_screen[l] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_corner_pixels();
      test_edge_clipping();
      test_collision_flag();
      test_clear_screen();
      test_unused_opcode();

      // random traffic under each idling pattern
      test_random_traffic(290);
      idle_pct  = 68;
      test_random_traffic(290);
      idle_pct  = 0;
      stall_pct = 68;
      test_random_traffic(290);
      idle_pct  = 32;
      stall_pct = 32;
      test_random_traffic(290);

      req_valid <= 1'b0;
      while (pending_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);

      if (pending_responses.size() != 0) begin
         report_mismatch("responses never returned", '0, 64'(pending_responses.size()));
      end
      if (mismatch_count == 0) begin
         $display("xor_sprite_draw_engine verification clean");
      end else begin
         $display("xor_sprite_draw_engine verification failed");
      end
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #2000000;
      $display("xor_sprite_draw_engine verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/xsde_pkg.sv
rtl/xsde_lane.sv
rtl/xsde_merge.sv
rtl/xor_sprite_draw_engine.sv
tb/tb_xor_sprite_draw_engine.sv
